// File: design/utli_pkg.sv
`timescale 1ns / 1ps
package utli_pkg;

    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 8;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_GRID_START   = 2'd0,
        REG_GRID_STEP    = 2'd1,
        REG_STEP_INVERSE = 2'd2,
        REG_INTERVALS    = 2'd3
    } reg_index_t;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic signed [31:0] grid_start;
        logic        [30:0] grid_step;
        logic        [31:0] step_inverse;
        logic        [7:0]  intervals;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi)
            sat32 = 32'sh7fffffff;
        else if (x < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = x[31:0];
    endfunction

endpackage

// File: design/uniform_table_linear_interp.sv
`timescale 1ns / 1ps
// Uniform-grid linear interpolation of three columns.
// s_axis beat: action 0 writes one grid point of all columns, action 1 queries.
// m_axis beat: six interpolated values and slopes plus a clamp flag (tuser).
// cfg channel: write grid_start, grid_step, grid_step_inverse, interval_count
// by index while the block is idle.
// One item per cycle sustained while results are taken. A query passes an offset
// stage, an index stage that also reads the dual-read column memories, a slope
// multiply (with the remainder worked out beside it), a value multiply and an
// output register, which drives m_axis_tvalid.
// Loads leave no result. The pipeline advances only when its last stage is
// free or taken, so a stalled receiver holds the result and backs up s_axis.
// Reset clears the pipeline valid bits and the registers to their defaults;
// table contents are undefined until loaded.
module uniform_table_linear_interp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: entry_index, entry_inv_volume, entry_inv_viscosity,
    // entry_inv_product, query_pressure
    input  logic [135:0] s_axis_tdata,
    // tuser: action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: inv_volume, inv_volume_slope, inv_viscosity,
    // inv_viscosity_slope, inv_product, inv_product_slope
    output logic [191:0] m_axis_tdata,
    // tuser: clamped
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import utli_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int NMAX   = (TABLE_DEPTH - 1 > 255) ? 255 : TABLE_DEPTH - 1;

    cfg_t cfg_reg;

    // configuration
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_start   <= '0;
            cfg_reg.grid_step    <= 31'd65536;
            cfg_reg.step_inverse <= 32'd65536;
            cfg_reg.intervals    <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_GRID_START:   cfg_reg.grid_start   <= cfg_data;
                REG_GRID_STEP:    cfg_reg.grid_step    <= cfg_data[30:0];
                REG_STEP_INVERSE: cfg_reg.step_inverse <= cfg_data;
                REG_INTERVALS:    cfg_reg.intervals    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline enable: last stage empty or taken
    logic en;
    logic [4:0] vld_reg;
    assign en            = !vld_reg[4] || m_axis_tready;
    assign s_axis_tready = en;

    logic        acc;
    logic        is_query;
    logic [7:0]  e_idx;
    logic signed [31:0] e_vol, e_vis, e_prd, p;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign is_query = action_t'(s_axis_tuser) == ACT_QUERY;
    assign e_idx = s_axis_tdata[7:0];
    assign e_vol = s_axis_tdata[39:8];
    assign e_vis = s_axis_tdata[71:40];
    assign e_prd = s_axis_tdata[103:72];
    assign p     = s_axis_tdata[135:104];

    // stage 0: range compare and offset
    logic [7:0]  n;
    logic signed [41:0] last;
    logic below, above;
    logic [32:0] off;
    always_comb
    begin
        n = cfg_reg.intervals;
        if (n == 8'd0)
            n = 8'd1;
        if (32'(n) > NMAX)
            n = 8'(NMAX);
        last  = 42'(cfg_reg.grid_start)
                + $signed({34'd0, n}) * $signed({11'd0, cfg_reg.grid_step});
        below = p < cfg_reg.grid_start;
        above = 42'(p) >= last;
        off   = 33'(34'(p) - 34'(cfg_reg.grid_start));
    end

    logic [32:0] off_reg;
    logic        below_reg, above_reg;
    logic [7:0]  n_reg;
    logic signed [31:0] p_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_reg   <= off;
            below_reg <= below;
            above_reg <= above;
            n_reg     <= n;
            p_reg     <= p;
        end
    end

    // stage 1: index and clamp
    logic [64:0] prod;
    logic [7:0]  k;
    logic        clamp;
    always_comb
    begin
        prod = 65'(off_reg) * 65'(cfg_reg.step_inverse);
        if (below_reg)
            k = 8'd0;
        else if (above_reg)
            k = n_reg;
        else if (prod[64:32] > 33'(n_reg - 8'd1))
            k = n_reg - 8'd1;
        else
            k = prod[39:32];
        clamp = below_reg || above_reg;
    end

    logic [7:0]  k_reg;
    logic signed [31:0] p1_reg;
    logic        clamp_reg, clamp2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg      <= k;
            p1_reg     <= p_reg;
            clamp_reg  <= clamp;
            clamp2_reg <= clamp_reg;
        end
    end

    // stage 2: remainder from the registered index
    logic signed [63:0] dt;
    logic signed [31:0] diff;
    always_comb
    begin
        dt = 64'(p1_reg) - (64'(cfg_reg.grid_start)
             + $signed({1'b0, k_reg}) * $signed({1'b0, cfg_reg.grid_step}));
        diff = clamp_reg ? 32'sd0 : sat32(dt);
    end

    logic [ADDR_W-1:0] rd_addr;
    assign rd_addr = ADDR_W'(k);

    logic wr_en;
    assign wr_en = acc && !is_query && (32'(e_idx) < TABLE_DEPTH);

    logic signed [31:0] val [3];
    logic signed [31:0] slp [3];
    logic signed [31:0] wd  [3];
    assign wd[0] = e_vol;
    assign wd[1] = e_vis;
    assign wd[2] = e_prd;

    for (genvar c = 0; c < 3; c++)
    begin : g_col
        utli_column #(.ADDR_W(ADDR_W)) u_col (
            .clk          (clk),
            .wr_en        (wr_en),
            .wr_addr      (ADDR_W'(e_idx)),
            .wr_data      (wd[c]),
            .rd_addr      (rd_addr),
            .en           (en),
            .step_inverse (cfg_reg.step_inverse),
            .diff_s2      (diff),
            .clamp_s2     (clamp_reg),
            .value        (val[c]),
            .slope        (slp[c])
        );
    end

    // valid shift: 0 off, 1 idx and mem, 2 slope, 3 value, 4 output
    logic c3_reg, c4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], acc && is_query};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg <= clamp2_reg;
            c4_reg <= c3_reg;
        end
    end

    // value/slope registers sit at stage 3 and feed the output register
    logic [191:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {slp[2], val[2], slp[1], val[1], slp[0], val[0]};
    end

    assign m_axis_tvalid = vld_reg[4];
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = c4_reg;

    ap_no_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !is_query) |=> !vld_reg[0])
        else $error("load beat produced a result");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    ap_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken during output stall");

endmodule

// File: design/utli_column.sv
`timescale 1ns / 1ps
// one table column: dual-read memory, slope and value pipeline
module utli_column #(
    parameter int ADDR_W = 8
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [31:0]        wr_data,
    input  logic [ADDR_W-1:0]         rd_addr,
    input  logic                      en,
    input  logic [31:0]               step_inverse,
    input  logic signed [31:0]        diff_s2,
    input  logic                      clamp_s2,
    output logic signed [31:0]        value,
    output logic signed [31:0]        slope
);
    import utli_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic signed [31:0] mem_a [DEPTH];
    logic signed [31:0] mem_b [DEPTH];
    logic signed [31:0] a_reg, b_reg;
    logic signed [31:0] a2_reg, s_reg, a3_reg;
    logic signed [32:0] d;
    logic signed [63:0] phi, plo, st, vt;
    logic signed [31:0] s_next, v_next, v_reg;
    logic               clamp3_reg;
    logic signed [31:0] diff3_reg;

    // two copies give two read ports; read data registered (stage 1)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
        end
        if (en)
        begin
            a_reg <= mem_a[rd_addr];
            b_reg <= mem_b[rd_addr + ADDR_W'(1)];
        end
    end

    // slope: d * inverse / 2^16, split in high and low halves
    assign d   = 33'(b_reg) - 33'(a_reg);
    assign phi = 64'(d) * $signed({1'b0, step_inverse[31:16]});
    assign plo = 64'(d) * $signed({1'b0, step_inverse[15:0]});
    assign st  = phi + (plo >>> 16);
    assign s_next = clamp_s2 ? 32'sd0 : sat32(st);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg     <= a_reg;
            s_reg      <= s_next;
            diff3_reg  <= diff_s2;
            clamp3_reg <= clamp_s2;
        end
    end

    // value: a + slope * diff / 2^16
    assign vt     = 64'(s_reg) * 64'(diff3_reg);
    assign v_next = clamp3_reg ? a2_reg : sat32(64'(a2_reg) + (vt >>> 16));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg  <= v_next;
            a3_reg <= s_reg;
        end
    end

    assign value = v_reg;
    assign slope = a3_reg;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import utli_pkg::*;

    localparam int DEPTH = 256;

    typedef struct packed {
        logic signed [31:0] inv_product_slope;
        logic signed [31:0] inv_product;
        logic signed [31:0] inv_viscosity_slope;
        logic signed [31:0] inv_viscosity;
        logic signed [31:0] inv_volume_slope;
        logic signed [31:0] inv_volume;
    } interp_data_t;

    typedef struct {
        interp_data_t data;
        logic         clamped;
    } interp_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // predictor copy of the tables and registers
    logic signed [31:0] vol_tab [DEPTH];
    logic signed [31:0] visc_tab [DEPTH];
    logic signed [31:0] prod_tab [DEPTH];
    logic signed [31:0] g_start;
    logic [30:0]        g_step;
    logic [31:0]        g_inv;
    logic [7:0]         g_count;

    interp_result_t pending_results[$];
    int errors = 0;
    int queries_sent = 0;
    int loads_sent = 0;
    int results_seen = 0;
    int clamps_seen = 0;

    uniform_table_linear_interp dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // floor division by 2^16
    function automatic longint floor16(input longint x);
        return x >>> 16;
    endfunction

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic void interp_one(input logic signed [31:0] a0,
                                       input logic signed [31:0] a1,
                                       input longint diff, input bit clamp,
                                       output logic signed [31:0] val,
                                       output logic signed [31:0] slope);
        longint d;
        longint s;
        longint hi;
        longint lo;
        if (clamp)
        begin
            val = a0;
            slope = 0;
            return;
        end
        d = longint'(a1) - longint'(a0);
        hi = longint'(g_inv[31:16]);
        lo = longint'(g_inv[15:0]);
        s = clip32(d * hi + floor16(d * lo));
        val = 32'(clip32(longint'(a0) + floor16(s * diff)));
        slope = 32'(s);
    endfunction

    function automatic interp_result_t predict_query(input logic signed [31:0] p);
        interp_result_t r;
        longint n;
        longint s;
        longint last;
        longint diff;
        longint unsigned idx;
        int k;
        bit clamp;
        n = g_count;
        if (n == 0)
            n = 1;
        if (n > DEPTH - 1)
            n = DEPTH - 1;
        s = g_start;
        last = s + n * longint'(g_step);
        diff = 0;
        clamp = 1;
        if (p < s)
            k = 0;
        else if (p >= last)
            k = int'(n);
        else
        begin
            clamp = 0;
            idx = (longint'(p) - s) * longint'(g_inv);
            idx = idx >> 32;
            if (idx > n - 1)
                idx = n - 1;
            k = int'(idx);
            diff = clip32(longint'(p) - (s + longint'(k) * longint'(g_step)));
        end
        interp_one(vol_tab[k], vol_tab[(k + 1) % DEPTH], diff, clamp,
                   r.data.inv_volume, r.data.inv_volume_slope);
        interp_one(visc_tab[k], visc_tab[(k + 1) % DEPTH], diff, clamp,
                   r.data.inv_viscosity, r.data.inv_viscosity_slope);
        interp_one(prod_tab[k], prod_tab[(k + 1) % DEPTH], diff, clamp,
                   r.data.inv_product, r.data.inv_product_slope);
        r.clamped = clamp;
        return r;
    endfunction

    // result receiver with random stalls
    initial
    begin
        int stall;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        interp_result_t exp_r;
        interp_data_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            results_seen++;
            if (m_axis_tuser)
                clamps_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.inv_volume !== exp_r.data.inv_volume)
                begin
                    $error("inv_volume exp %0d got %0d", exp_r.data.inv_volume,
                           got.inv_volume);
                    errors++;
                end
                if (got.inv_volume_slope !== exp_r.data.inv_volume_slope)
                begin
                    $error("inv_volume_slope exp %0d got %0d",
                           exp_r.data.inv_volume_slope, got.inv_volume_slope);
                    errors++;
                end
                if (got.inv_viscosity !== exp_r.data.inv_viscosity)
                begin
                    $error("inv_viscosity exp %0d got %0d",
                           exp_r.data.inv_viscosity, got.inv_viscosity);
                    errors++;
                end
                if (got.inv_viscosity_slope !== exp_r.data.inv_viscosity_slope)
                begin
                    $error("inv_viscosity_slope exp %0d got %0d",
                           exp_r.data.inv_viscosity_slope, got.inv_viscosity_slope);
                    errors++;
                end
                if (got.inv_product !== exp_r.data.inv_product)
                begin
                    $error("inv_product exp %0d got %0d", exp_r.data.inv_product,
                           got.inv_product);
                    errors++;
                end
                if (got.inv_product_slope !== exp_r.data.inv_product_slope)
                begin
                    $error("inv_product_slope exp %0d got %0d",
                           exp_r.data.inv_product_slope, got.inv_product_slope);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.clamped)
                begin
                    $error("clamped exp %0d got %0d", exp_r.clamped, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // send one beat after a random gap; valid stays high across back-to-back beats
    task automatic send_item(input action_t act, input logic [7:0] idx,
                             input logic [31:0] vol, input logic [31:0] visc,
                             input logic [31:0] prod, input logic [31:0] pressure);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tdata <= {pressure, prod, visc, vol, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (act == ACT_LOAD)
        begin
            vol_tab[idx] = vol;
            visc_tab[idx] = visc;
            prod_tab[idx] = prod;
            loads_sent++;
        end
        else
        begin
            pending_results.push_back(predict_query(pressure));
            queries_sent++;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t r, input logic [31:0] value);
        cfg_valid <= 1;
        cfg_index <= r;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (r)
            REG_GRID_START:   g_start = value;
            REG_GRID_STEP:    g_step = value[30:0];
            REG_STEP_INVERSE: g_inv = value;
            default:          g_count = value[7:0];
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // set up a grid; inverse worked out from the step
    task automatic set_grid(input logic [31:0] start, input logic [30:0] step,
                            input logic [7:0] count);
        longint unsigned inv;
        inv = (64'd1 << 32) / step;
        if (inv > 32'hffffffff)
            inv = 32'hffffffff;
        write_reg(REG_GRID_START, start);
        write_reg(REG_GRID_STEP, 32'(step));
        write_reg(REG_STEP_INVERSE, inv[31:0]);
        write_reg(REG_INTERVALS, 32'(count));
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h02000000) - 32'h01000000;
            default: return $urandom();
        endcase
    endfunction

    // load every point 0..count so no result uses an unwritten entry
    task automatic load_table(input int count);
        for (int i = 0; i <= count; i++)
            send_item(ACT_LOAD, 8'(i), rand_value(), rand_value(), rand_value(),
                      $urandom());
    endtask

    function automatic logic [31:0] rand_pressure();
        longint span;
        span = longint'(g_step) * (g_count == 0 ? 1 : g_count);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return g_start - $urandom_range(0, 3);
            2: return 32'(longint'(g_start) + span + $urandom_range(0, 3) - 2);
            default: return 32'(longint'(g_start) + (longint'($urandom()) % (span + 1)));
        endcase
    endfunction

    task automatic test_directed();
        set_grid(32'hfffe0000, 31'h00010000, 8'd4);
        load_table(4);
        send_item(ACT_LOAD, 8'd2, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
        send_item(ACT_LOAD, 8'd3, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0);
        send_item(ACT_QUERY, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                  32'h80000000);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'h7fffffff);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'hfffe0000);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'hfffdffff);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'h00020000);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'h0001ffff);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'h00008000);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'h00010000);
        drain();
        // zero interval count behaves as one
        write_reg(REG_INTERVALS, 32'd0);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'hfffe8000);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'hffff0000);
        drain();
        // inverse too large makes the index overrun and get clamped
        write_reg(REG_INTERVALS, 32'd4);
        write_reg(REG_STEP_INVERSE, 32'hffffffff);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'h0001fff0);
        send_item(ACT_QUERY, 0, 0, 0, 0, 32'hffff8000);
        drain();
    endtask

    task automatic test_random(input int n_items);
        int cfgs [5] = '{1, 255, 7, 16, 3};
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_grid(32'h80000000, 31'h7fffffff, 8'd1);
                1: set_grid(32'h7ffffff0 - 32'h00ff0000, 31'h00000001, 8'd255);
                2: set_grid($urandom(), 31'($urandom_range(1, 32'h00100000)), 8'd7);
                3: set_grid(-32'sd100000, 31'h00002000, 8'd16);
                default: set_grid($urandom(), 31'($urandom_range(1, 32'h01000000)), 8'd3);
            endcase
            load_table(cfgs[phase]);
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(ACT_LOAD, 8'($urandom_range(0, cfgs[phase])), rand_value(),
                              rand_value(), rand_value(), $urandom());
                else
                    send_item(ACT_QUERY, 8'($urandom()), $urandom(), $urandom(),
                              $urandom(), rand_pressure());
            end
            // hold the sender until the pipeline is empty
            drain();
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        cfg_valid = 0;
        cfg_index = REG_GRID_START;
        cfg_data = 0;
        g_start = 0;
        g_step = 65536;
        g_inv = 65536;
        g_count = 1;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_random(50);
        $display("covered %0d loads and %0d queries, %0d results of which %0d clamped",
                 loads_sent, queries_sent, results_seen, clamps_seen);
        $display("grid settings: extreme start and step, 1 to 255 intervals, zero count");
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
